[design/bilinear_texel_sampler_wrap_assert.svh]
// Assertion macros shared by the checker of the bilinear texel sampler.
// Needs nothing else; take it by include in a file that asserts.
`ifndef BILINEAR_TEXEL_SAMPLER_WRAP_ASSERT_SVH
`define BILINEAR_TEXEL_SAMPLER_WRAP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define BTS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent ends.
`define BTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/bts_pkg.sv]
// Shared types, constants and lerp arithmetic of the bilinear texel sampler.
// No dependencies; used by bts_filter, the top level, the checker and the testbench.
`default_nettype none

package bts_pkg;

   // Default of the largest texture side, as log2
   localparam int MAX_SIDE_LOG2_DEF = 8;

   // Configuration port
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 4;
   localparam logic [CSR_ADDR_W-1:0] CSR_WIDTH_LOG2  = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_HEIGHT_LOG2 = 1'b1;
   localparam logic [CSR_DATA_W-1:0] LOG2_RESET      = 4'd8;

   // Item layout
   localparam int TEXEL_W   = 32;
   localparam int CHAN_W    = 8;
   localparam int NUM_CHAN  = 4;
   localparam int FRAC_W    = 16;
   localparam int REQ_DATA_W = 112;
   localparam int RSP_DATA_W = 32;

   // Mode codes carried in tuser
   localparam logic MODE_WRITE  = 1'b0;
   localparam logic MODE_SAMPLE = 1'b1;

   typedef logic [CHAN_W-1:0] chan_type;
   typedef logic signed [24:0] prod_type;

   // Stage-1 control handed to the filter
   typedef struct packed {
      logic                valid;
      logic [FRAC_W-1:0]   frac_x;
      logic [FRAC_W-1:0]   frac_y;
   } samp_ctl_type;

   // (e - s) * f, 9-bit signed difference times unsigned 16-bit fraction
   function automatic prod_type lerp_prod(input chan_type s, input chan_type e,
                                          input logic [FRAC_W-1:0] f);
      logic signed [8:0]  d;
      logic signed [16:0] fs;
      logic signed [25:0] p;
      d  = $signed({1'b0, e}) - $signed({1'b0, s});
      fs = $signed({1'b0, f});
      p  = d * fs;
      return $signed(p[24:0]);
   endfunction

   // s + trunc_toward_zero(p / 65536), modulo 256
   function automatic chan_type lerp_finish(input chan_type s, input prod_type p);
      prod_type pb;
      pb = p + (p[24] ? 25'sd65535 : 25'sd0);
      return s + pb[23:16];
   endfunction

endpackage

`default_nettype wire

[design/bilinear_texel_sampler_wrap.sv]
// Channel   | dir | handshake           | payload
// req       | in  | req_tvalid/tready   | tuser: mode; tdata: col,row,texel,coord_x,coord_y
// rsp       | out | rsp_tvalid/tready   | tdata: blue,green,red,alpha
// csr       | in  | csr_we              | csr_addr, csr_wdata (width_log2, height_log2)
//
// One item per cycle unless rsp stalls; a sample passes stages 1 to 4 on its way to rsp.
// The texture is held twice, each copy with two read ports, so all four
// neighbors are read in the same cycle; writes go to both copies at transfer.
// Reset clears control only; texels are undefined until written.
// A stalled rsp backs up stage by stage; empty stages still take items.
// Top level of the bilinear texel sampler; depends on bts_pkg, bts_texmem, bts_filter.
`default_nettype none

module bilinear_texel_sampler_wrap #(
   parameter int MAX_SIDE_LOG2 = bts_pkg::MAX_SIDE_LOG2_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // [0] mode
   input  wire logic [0:0]                        req_tuser,
   // [7:0] write_col, [15:8] write_row, [47:16] texel_value,
   // [79:48] coord_x, [111:80] coord_y
   input  wire logic [bts_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [7:0] out_blue, [15:8] out_green, [23:16] out_red, [31:24] out_alpha
   output logic [bts_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   input  wire logic                              csr_we,
   input  wire logic [bts_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire logic [bts_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int M  = MAX_SIDE_LOG2;
   localparam int AW = 2 * MAX_SIDE_LOG2;
   localparam logic [bts_pkg::CSR_DATA_W-1:0] MAX_L2 = bts_pkg::CSR_DATA_W'(MAX_SIDE_LOG2);

   // configuration registers
   logic [bts_pkg::CSR_DATA_W-1:0] width_log2_ff, width_log2_in;
   logic [bts_pkg::CSR_DATA_W-1:0] height_log2_ff, height_log2_in;
   logic [bts_pkg::CSR_DATA_W-1:0] wl, hl;

   // request fields
   logic        mode;
   logic [7:0]  write_col, write_row;
   logic [31:0] texel_value, coord_x, coord_y;
   logic [15:0] wcol16, wrow16;
   logic [M-1:0] col_w, row_w, c0, c1, r0, r1;

   logic accept, wr_en, en1;
   logic [AW-1:0] wr_idx, idx00, idx10, idx01, idx11;

   // stage 1 control
   logic                          v1_ff, v1_in;
   logic [bts_pkg::FRAC_W-1:0]    fx_ff, fy_ff;
   bts_pkg::samp_ctl_type         ctl;
   logic                          take;

   logic [bts_pkg::TEXEL_W-1:0]   p00, p10, p01, p11;

   // linear entry: texels stored column by column
   function automatic logic [AW-1:0] tex_index(input logic [M-1:0] col,
                                                input logic [M-1:0] row,
                                                input logic [bts_pkg::CSR_DATA_W-1:0] wlog,
                                                input logic [bts_pkg::CSR_DATA_W-1:0] hlog);
      logic [M-1:0]  wmask;
      logic [M-1:0]  hmask;
      logic [AW-1:0] cx;
      wmask = ~({M{1'b1}} << wlog);
      hmask = ~({M{1'b1}} << hlog);
      cx    = {{M{1'b0}}, col & wmask};
      return (cx << hlog) + {{M{1'b0}}, row & hmask};
   endfunction

   // unpack
   assign mode        = req_tuser[0];
   assign write_col   = req_tdata[7:0];
   assign write_row   = req_tdata[15:8];
   assign texel_value = req_tdata[47:16];
   assign coord_x     = req_tdata[79:48];
   assign coord_y     = req_tdata[111:80];

   // effective sizes, clamped to the store
   assign wl = (width_log2_ff  > MAX_L2) ? MAX_L2 : width_log2_ff;
   assign hl = (height_log2_ff > MAX_L2) ? MAX_L2 : height_log2_ff;

   // configuration writes
   always_comb begin
      width_log2_in  = width_log2_ff;
      height_log2_in = height_log2_ff;
      if (csr_we) begin
         case (csr_addr)
            bts_pkg::CSR_WIDTH_LOG2:  width_log2_in  = csr_wdata;
            bts_pkg::CSR_HEIGHT_LOG2: height_log2_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // addresses of the written texel and the four neighbors
   always_comb begin
      wcol16 = {8'd0, write_col};
      wrow16 = {8'd0, write_row};
      col_w  = wcol16[M-1:0];
      row_w  = wrow16[M-1:0];
      c0     = coord_x[16 +: M];
      r0     = coord_y[16 +: M];
      c1     = c0 + M'(1);
      r1     = r0 + M'(1);
      wr_idx = tex_index(col_w, row_w, wl, hl);
      idx00  = tex_index(c0, r0, wl, hl);
      idx10  = tex_index(c1, r0, wl, hl);
      idx01  = tex_index(c0, r1, wl, hl);
      idx11  = tex_index(c1, r1, wl, hl);
   end

   // handshake; stage 1 is the memory read register
   assign en1        = !v1_ff || take;
   assign req_tready = en1;
   assign accept     = req_tvalid && en1;
   assign wr_en      = accept && (mode == bts_pkg::MODE_WRITE);
   assign v1_in      = accept && (mode == bts_pkg::MODE_SAMPLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_log2_ff  <= bts_pkg::LOG2_RESET;
         height_log2_ff <= bts_pkg::LOG2_RESET;
         v1_ff          <= 1'b0;
      end else begin
         width_log2_ff  <= width_log2_in;
         height_log2_ff <= height_log2_in;
         if (en1) begin
            v1_ff <= v1_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         fx_ff <= coord_x[15:0];
         fy_ff <= coord_y[15:0];
      end
   end

   // top-row copy
   bts_texmem #(.ADDR_W(AW), .DATA_W(bts_pkg::TEXEL_W)) u_mem_top (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_idx),
      .wr_data   (texel_value),
      .rd_en     (en1),
      .rd_addr_a (idx00),
      .rd_addr_b (idx10),
      .rd_data_a (p00),
      .rd_data_b (p10)
   );

   // bottom-row copy
   bts_texmem #(.ADDR_W(AW), .DATA_W(bts_pkg::TEXEL_W)) u_mem_bot (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_idx),
      .wr_data   (texel_value),
      .rd_en     (en1),
      .rd_addr_a (idx01),
      .rd_addr_b (idx11),
      .rd_data_a (p01),
      .rd_data_b (p11)
   );

   assign ctl.valid  = v1_ff;
   assign ctl.frac_x = fx_ff;
   assign ctl.frac_y = fy_ff;

   bts_filter u_filter (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .p00        (p00),
      .p10        (p10),
      .p01        (p01),
      .p11        (p11),
      .take       (take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

[design/bts_texmem.sv]
// One copy of the texel store: one write port, two registered read ports.
// Uses no package items; sized by its parameters.
`default_nettype none

module bts_texmem #(
   parameter int ADDR_W = 16,
   parameter int DATA_W = 32
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr_a,
   input  wire logic [ADDR_W-1:0] rd_addr_b,
   output logic      [DATA_W-1:0] rd_data_a,
   output logic      [DATA_W-1:0] rd_data_b
);

   logic [DATA_W-1:0] mem_ff [2**ADDR_W];
   logic [DATA_W-1:0] rd_a_ff;
   logic [DATA_W-1:0] rd_b_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read ports, held while the next stage stalls
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

[design/bts_filter.sv]
// Bilinear filter pipeline: horizontal products, horizontal/vertical lerp, output register.
// Depends on bts_pkg for the lerp functions and the stage-1 control struct.
`default_nettype none

module bts_filter (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire bts_pkg::samp_ctl_type         ctl,
   input  wire logic [bts_pkg::TEXEL_W-1:0]   p00,
   input  wire logic [bts_pkg::TEXEL_W-1:0]   p10,
   input  wire logic [bts_pkg::TEXEL_W-1:0]   p01,
   input  wire logic [bts_pkg::TEXEL_W-1:0]   p11,
   output logic                               take,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [bts_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   localparam int NC = bts_pkg::NUM_CHAN;
   localparam int CW = bts_pkg::CHAN_W;

   // stage 2: horizontal products
   logic                         v2_ff, v2_in;
   logic [bts_pkg::FRAC_W-1:0]   fy2_ff;
   bts_pkg::chan_type            s_top_ff [NC];
   bts_pkg::chan_type            s_bot_ff [NC];
   bts_pkg::prod_type            p_top_ff [NC];
   bts_pkg::prod_type            p_bot_ff [NC];
   bts_pkg::chan_type            s_top_in [NC];
   bts_pkg::chan_type            s_bot_in [NC];
   bts_pkg::prod_type            p_top_in [NC];
   bts_pkg::prod_type            p_bot_in [NC];

   // stage 3: top row and vertical products
   logic                         v3_ff, v3_in;
   bts_pkg::chan_type            top_ff [NC];
   bts_pkg::prod_type            pv_ff  [NC];
   bts_pkg::chan_type            top_in [NC];
   bts_pkg::prod_type            pv_in  [NC];

   // stage 4: output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [bts_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic en2, en3, en4;

   // stage advance chain; a stage fills whenever it is empty
   assign en4  = !rsp_valid_ff || rsp_tready;
   assign en3  = !v3_ff || en4;
   assign en2  = !v2_ff || en3;
   assign take = en2;

   always_comb begin
      v2_in = ctl.valid;
      for (int k = 0; k < NC; k++) begin
         s_top_in[k] = p00[k*CW +: CW];
         s_bot_in[k] = p01[k*CW +: CW];
         p_top_in[k] = bts_pkg::lerp_prod(p00[k*CW +: CW], p10[k*CW +: CW], ctl.frac_x);
         p_bot_in[k] = bts_pkg::lerp_prod(p01[k*CW +: CW], p11[k*CW +: CW], ctl.frac_x);
      end
   end

   always_comb begin
      bts_pkg::chan_type bot;
      bot   = '0;
      v3_in = v2_ff;
      for (int k = 0; k < NC; k++) begin
         top_in[k] = bts_pkg::lerp_finish(s_top_ff[k], p_top_ff[k]);
         bot       = bts_pkg::lerp_finish(s_bot_ff[k], p_bot_ff[k]);
         pv_in[k]  = bts_pkg::lerp_prod(top_in[k], bot, fy2_ff);
      end
   end

   always_comb begin
      rsp_valid_in = v3_ff;
      for (int k = 0; k < NC; k++) begin
         rsp_data_in[k*CW +: CW] = bts_pkg::lerp_finish(top_ff[k], pv_ff[k]);
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en2) begin
            v2_ff <= v2_in;
         end
         if (en3) begin
            v3_ff <= v3_in;
         end
         if (en4) begin
            rsp_valid_ff <= rsp_valid_in;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (en2) begin
         fy2_ff   <= ctl.frac_y;
         s_top_ff <= s_top_in;
         s_bot_ff <= s_bot_in;
         p_top_ff <= p_top_in;
         p_bot_ff <= p_bot_in;
      end
      if (en3) begin
         top_ff <= top_in;
         pv_ff  <= pv_in;
      end
      if (en4) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

[design/bts_checker.sv]
// Port-level checks of the bilinear texel sampler, bound to its top level.
// Depends on bilinear_texel_sampler_wrap_assert.svh and bts_pkg for widths.
`default_nettype none
`include "bilinear_texel_sampler_wrap_assert.svh"

module bts_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_tvalid,
   input wire logic                          req_tready,
   input wire logic [0:0]                    req_tuser,
   input wire logic                          rsp_tvalid,
   input wire logic                          rsp_tready,
   input wire logic [bts_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // a stalled result stays put
   `BTS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "rsp changed while stalled")

   // with the output empty nothing blocks the input
   `BTS_ASSERT_IMP(a_ready_when_empty, clock, reset, !rsp_tvalid, req_tready, "req_tready low with empty output")

   // no result right after reset
   `BTS_ASSERT_IMP(a_idle_after_reset, clock, reset, $fell(reset), !rsp_tvalid, "rsp_tvalid high after reset")

   // an unstalled sample reaches the output through stages 1 to 4
   `BTS_ASSERT_NEXT(a_sample_latency, clock, reset, req_tvalid && req_tready && req_tuser[0] && !rsp_tvalid ##1 rsp_tready ##1 rsp_tready ##1 rsp_tready, rsp_tvalid, "sample transfer gave no result")

endmodule

bind bilinear_texel_sampler_wrap bts_checker u_bts_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

[sim/testbench.sv]
// Self-checking bench for the bilinear texel sampler: loads texels, samples them
// and compares every filtered color against an in-bench bilinear predictor.
// Depends on bts_pkg and the bilinear_texel_sampler_wrap RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int TAIL_CYCLES   = 10;
   localparam int PHASE_ITEMS   = 130;
   localparam int SIDE_LOG2_MAX = 8;

   // Filtered color, blue in the low byte as on rsp_tdata
   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } color_type;

   logic                             clock      = 1'b0;
   logic                             reset      = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [0:0]                       req_tuser  = '0;
   logic [bts_pkg::REQ_DATA_W-1:0]   req_tdata  = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [bts_pkg::RSP_DATA_W-1:0]   rsp_tdata;
   logic                             csr_we     = 1'b0;
   logic [bts_pkg::CSR_ADDR_W-1:0]   csr_addr   = '0;
   logic [bts_pkg::CSR_DATA_W-1:0]   csr_wdata  = '0;

   // Predictor state: texture copy, which entries hold data, log2 registers
   logic [31:0]             texel_mem   [0:65535];
   bit                      texel_known [0:65535];
   logic [3:0]              cfg_width_log2  = bts_pkg::LOG2_RESET;
   logic [3:0]              cfg_height_log2 = bts_pkg::LOG2_RESET;
   color_type               pending_colors[$];

   int                      error_count   = 0;
   int                      cycle_count   = 0;
   int                      sent_count    = 0;
   int                      send_idle_pct = 0;
   int                      stall_pct     = 0;

   bilinear_texel_sampler_wrap u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   // Receiver back-pressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // ---------------------------------------------------------------- predictor

   // log2 registers above the largest side act as the largest side
   function automatic logic [3:0] side_log2(logic [3:0] v);
      return (v > SIDE_LOG2_MAX) ? 4'(SIDE_LOG2_MAX) : v;
   endfunction

   // Column-major texel address with repeat wrap on both indexes
   function automatic logic [15:0] texel_addr(logic [31:0] col, logic [31:0] row);
      logic [3:0]  wl;
      logic [3:0]  hl;
      logic [31:0] wmask;
      logic [31:0] hmask;
      logic [31:0] a;
      wl    = side_log2(cfg_width_log2);
      hl    = side_log2(cfg_height_log2);
      wmask = (32'd1 << wl) - 32'd1;
      hmask = (32'd1 << hl) - 32'd1;
      a     = ((col & wmask) << hl) + (row & hmask);
      return a[15:0];
   endfunction

   // s + trunc_toward_zero((e - s) * f / 65536), modulo 256
   function automatic logic [7:0] chan_blend(logic [7:0] s, logic [7:0] e, logic [15:0] f);
      int d;
      int p;
      int q;
      int r;
      d = int'({24'd0, e}) - int'({24'd0, s});
      p = d * int'({16'd0, f});
      q = p / 65536;
      r = int'({24'd0, s}) + q;
      return r[7:0];
   endfunction

   function automatic logic [31:0] texel_blend(logic [31:0] s, logic [31:0] e,
                                               logic [15:0] f);
      logic [31:0] r;
      for (int k = 0; k < 4; k++)
         r[8*k +: 8] = chan_blend(s[8*k +: 8], e[8*k +: 8], f);
      return r;
   endfunction

   // Bilinear filter of the four wrapped neighbors of a 16.16 coordinate
   function automatic color_type filtered_color(logic [31:0] x, logic [31:0] y);
      logic [31:0] xi;
      logic [31:0] yi;
      logic [31:0] top_row;
      logic [31:0] bot_row;
      xi      = {16'd0, x[31:16]};
      yi      = {16'd0, y[31:16]};
      top_row = texel_blend(texel_mem[texel_addr(xi, yi)],
                            texel_mem[texel_addr(xi + 1, yi)], x[15:0]);
      bot_row = texel_blend(texel_mem[texel_addr(xi, yi + 1)],
                            texel_mem[texel_addr(xi + 1, yi + 1)], x[15:0]);
      return color_type'(texel_blend(top_row, bot_row, y[15:0]));
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t ns mismatch %s: got %h want %h", $time, what, got, want);
      error_count++;
   endtask

   task automatic check_chan(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
         report_mismatch(name, {24'd0, got}, {24'd0, want});
   endtask

   // Compare each rsp transfer with the oldest predicted color
   always @(posedge clock) begin : rsp_check
      color_type got;
      color_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_colors.size() == 0) begin
            report_mismatch("result with nothing pending", got, 32'd0);
         end else begin
            want = pending_colors.pop_front();
            check_chan("out_blue",  got.blue,  want.blue);
            check_chan("out_green", got.green, want.green);
            check_chan("out_red",   got.red,   want.red);
            check_chan("out_alpha", got.alpha, want.alpha);
         end
      end
   end

   // ---------------------------------------------------------------- driving

   // One req transfer; the predictor is updated at the accepting edge
   task automatic send_item(logic mode, logic [7:0] col, logic [7:0] row,
                            logic [31:0] texel, logic [31:0] x, logic [31:0] y);
      logic [15:0] addr;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {y, x, texel, row, col};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_count++;
      if (mode == bts_pkg::MODE_WRITE) begin
         addr = texel_addr({24'd0, col}, {24'd0, row});
         texel_mem[addr]   = texel;
         texel_known[addr] = 1'b1;
      end else begin
         pending_colors.push_back(filtered_color(x, y));
      end
   endtask

   task automatic write_texel(logic [7:0] col, logic [7:0] row, logic [31:0] texel);
      send_item(bts_pkg::MODE_WRITE, col, row, texel, $urandom(), $urandom());
   endtask

   // Sample, first loading any neighbor that was never written
   task automatic sample_at(logic [31:0] x, logic [31:0] y);
      logic [31:0] col;
      logic [31:0] row;
      logic [7:0]  wmask;
      logic [7:0]  hmask;
      wmask = 8'((16'd1 << side_log2(cfg_width_log2)) - 16'd1);
      hmask = 8'((16'd1 << side_log2(cfg_height_log2)) - 16'd1);
      for (int dy = 0; dy < 2; dy++) begin
         for (int dx = 0; dx < 2; dx++) begin
            col = {16'd0, x[31:16]} + dx;
            row = {16'd0, y[31:16]} + dy;
            // bits above the mask are random: the block must drop them
            if (!texel_known[texel_addr(col, row)])
               write_texel((col[7:0] & wmask) | (8'($urandom()) & ~wmask),
                           (row[7:0] & hmask) | (8'($urandom()) & ~hmask),
                           $urandom());
         end
      end
      send_item(bts_pkg::MODE_SAMPLE, 8'($urandom()), 8'($urandom()), $urandom(), x, y);
   endtask

   // Hold the sender until all results are back and the pipe has emptied
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_colors.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // Both log2 registers, written only while idle
   task automatic set_log2(logic [3:0] w, logic [3:0] h);
      wait_idle();
      csr_we    <= 1'b1;
      csr_addr  <= bts_pkg::CSR_WIDTH_LOG2;
      csr_wdata <= w;
      @(posedge clock);
      cfg_width_log2 = w;
      csr_addr  <= bts_pkg::CSR_HEIGHT_LOG2;
      csr_wdata <= h;
      @(posedge clock);
      cfg_height_log2 = h;
      csr_we    <= 1'b0;
   endtask

   // ---------------------------------------------------------------- tests

   // Full-size texture, extreme texels at the four wrap corners
   task automatic test_corners();
      set_log2(4'd8, 4'd8);
      write_texel(8'd255, 8'd255, 32'hFFFF_FFFF);
      write_texel(8'd0,   8'd0,   32'h0000_0000);
      write_texel(8'd0,   8'd255, 32'hFF00_FF00);
      write_texel(8'd255, 8'd0,   32'h00FF_00FF);
      sample_at(32'h00FF_0000, 32'h00FF_0000);   // zero fractions
      sample_at(32'h00FF_FFFF, 32'h00FF_FFFF);   // largest fractions
      sample_at(32'hFFFF_FFFF, 32'hFFFF_8000);   // negative, floor wraps
      sample_at(32'h7FFF_FFFF, 32'h80FF_0000);   // most positive / large negative
      sample_at(32'h80FF_0001, 32'h7FFF_FFFF);
   endtask

   // Oversized log2 clamps to the largest side; 1x1 texture folds everything
   task automatic test_log2_limits();
      set_log2(4'd15, 4'd12);
      sample_at(32'hFFFF_7FFF, 32'h00FF_C000);
      sample_at(32'h01FF_0000, 32'hFFFF_0001);
      set_log2(4'd0, 4'd0);
      write_texel(8'd200, 8'd100, 32'hA5C3_3C5A);
      sample_at(32'h8000_1234, 32'h7FFF_ABCD);
      sample_at(32'h0000_0000, 32'hFFFF_FFFF);
   endtask

   function automatic logic [31:0] rand_coord();
      logic [31:0] v;
      v = $urandom();
      case ($urandom_range(0, 7))
         0: v[15:0] = 16'h0000;
         1: v[15:0] = 16'hFFFF;
         default: ;
      endcase
      return v;
   endfunction

   function automatic logic [31:0] rand_texel();
      case ($urandom_range(0, 9))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   task automatic random_op();
      if ($urandom_range(0, 99) < 40)
         write_texel(8'($urandom()), 8'($urandom()), rand_texel());
      else
         sample_at(rand_coord(), rand_coord());
   endtask

   // Mixed writes and samples over several sizes and idle patterns
   task automatic test_random_traffic();
      int phase_w [8] = '{8, 0, 3, 8, 1, 15, 2, 5};
      int phase_h [8] = '{8, 0, 5, 1, 8, 9, 2, 0};
      int stop_at;
      for (int ph = 0; ph < 8; ph++) begin
         set_log2(4'(phase_w[ph]), 4'(phase_h[ph]));
         case (ph % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 70; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 70; end
            default: begin send_idle_pct = 37; stall_pct = 37; end
         endcase
         stop_at = sent_count + PHASE_ITEMS / 2;
         while (sent_count < stop_at) random_op();
         // let the pipe drain completely mid-phase
         wait_idle();
         stop_at = sent_count + PHASE_ITEMS / 2;
         while (sent_count < stop_at) random_op();
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_corners();
      test_log2_limits();
      test_random_traffic();
      wait_idle();
      if (error_count == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule
